### rtl/aff3p_pkg.sv
`default_nettype none

package aff3p_pkg;

   // default configuration
   localparam int COORD_BITS_DEF    = 16;
   localparam int OUT_FRAC_BITS_DEF = 24;

   // fixed formats
   localparam int COORD_FRAC  = 4;
   localparam int FIELD_W     = 16;
   localparam int OUT_W       = 48;
   localparam int NUM_COORDS  = 12;
   localparam int NUM_LANES   = 6;
   localparam int QUEUE_DEPTH = 4;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_SRC_DEGEN = 2'd1;
   localparam logic [1:0] ST_DST_DEGEN = 2'd2;
   localparam logic [1:0] ST_SAT       = 2'd3;

   typedef logic [3:0] cidx_type;

   // coordinate order: px py qx qy rx ry Px Py Qx Qy Rx Ry
   typedef struct packed {
      logic signed [FIELD_W-1:0] src_p_x;
      logic signed [FIELD_W-1:0] src_p_y;
      logic signed [FIELD_W-1:0] src_q_x;
      logic signed [FIELD_W-1:0] src_q_y;
      logic signed [FIELD_W-1:0] src_r_x;
      logic signed [FIELD_W-1:0] src_r_y;
      logic signed [FIELD_W-1:0] dst_p_x;
      logic signed [FIELD_W-1:0] dst_p_y;
      logic signed [FIELD_W-1:0] dst_q_x;
      logic signed [FIELD_W-1:0] dst_q_y;
      logic signed [FIELD_W-1:0] dst_r_x;
      logic signed [FIELD_W-1:0] dst_r_y;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] m00;
      logic signed [OUT_W-1:0] m01;
      logic signed [OUT_W-1:0] m10;
      logic signed [OUT_W-1:0] m11;
      logic signed [OUT_W-1:0] shift_x;
      logic signed [OUT_W-1:0] shift_y;
      logic        [1:0]       status;
   } rsp_type;

   // coordinate differences: row r, term k is c[DIFF_HI] - c[DIFF_LO]
   // rows: source y diffs, target y diffs, m00 x diffs, m01 x diffs, m10 y diffs
   localparam cidx_type DIFF_HI [5][3] = '{
      '{4'd5,  4'd1, 4'd3},
      '{4'd11, 4'd7, 4'd9},
      '{4'd6,  4'd8, 4'd10},
      '{4'd10, 4'd6, 4'd8},
      '{4'd7,  4'd9, 4'd11}
   };
   localparam cidx_type DIFF_LO [5][3] = '{
      '{4'd1,  4'd3,  4'd5},
      '{4'd7,  4'd9,  4'd11},
      '{4'd10, 4'd6,  4'd8},
      '{4'd6,  4'd8,  4'd10},
      '{4'd11, 4'd7,  4'd9}
   };

   // sums: source area, target area, m00, m01, m10, m11
   localparam logic [2:0] SUM_ROW [6] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd1};
   localparam cidx_type SUM_MUL [6][3] = '{
      '{4'd2, 4'd4,  4'd0},
      '{4'd8, 4'd10, 4'd6},
      '{4'd3, 4'd5,  4'd1},
      '{4'd2, 4'd4,  4'd0},
      '{4'd3, 4'd5,  4'd1},
      '{4'd2, 4'd4,  4'd0}
   };

   // translation terms: (c[A]*c[B] - c[C]*c[D]) * c[M]
   localparam cidx_type TI_A [6] = '{4'd5, 4'd8, 4'd3,  4'd11, 4'd7, 4'd4};
   localparam cidx_type TI_B [6] = '{4'd6, 4'd1, 4'd10, 4'd0,  4'd2, 4'd9};
   localparam cidx_type TI_C [6] = '{4'd10, 4'd3, 4'd8, 4'd4,  4'd0, 4'd11};
   localparam cidx_type TI_D [6] = '{4'd1, 4'd6, 4'd5,  4'd7,  4'd9, 4'd2};
   localparam cidx_type TI_M [6] = '{4'd2, 4'd4, 4'd0,  4'd3,  4'd5, 4'd1};

endpackage

`default_nettype wire

### rtl/aff3p_front.sv
`default_nettype none

module aff3p_front #(
   parameter int COORD_BITS = aff3p_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  aff3p_pkg::req_type              in_data,
   input  logic                            enable,
   output logic                            out_valid,
   output logic                            out_src_zero,
   output logic                            out_dst_zero,
   output logic signed [2*COORD_BITS+2:0]  out_d,
   output logic signed [2*COORD_BITS+2:0]  out_nm [4],
   output logic signed [3*COORD_BITS+2:0]  out_nvx,
   output logic signed [3*COORD_BITS+2:0]  out_nvy
);

   localparam int C  = COORD_BITS;
   localparam int FW = aff3p_pkg::FIELD_W;
   localparam int NC = aff3p_pkg::NUM_COORDS;
   localparam int W1 = C + 1;
   localparam int WI = 2 * C + 1;
   localparam int W2 = 2 * C + 3;
   localparam int WT = 3 * C + 1;
   localparam int W3 = 3 * C + 3;

   logic signed [FW-1:0]   raw [NC];
   logic [FW+C-1:0]        ext [NC];
   logic signed [C-1:0]    crd [NC];

   logic                   v1_ff, v2_ff, v3_ff;
   logic signed [C-1:0]    c1_ff [NC];
   logic signed [W1-1:0]   dif_in [5][3];
   logic signed [W1-1:0]   dif_ff [5][3];
   logic signed [WI-1:0]   ti_in [6];
   logic signed [WI-1:0]   ti_ff [6];
   logic signed [WI-1:0]   pr_in [6][3];
   logic signed [WI-1:0]   pr_ff [6][3];
   logic signed [WT-1:0]   tp_in [6];
   logic signed [WT-1:0]   tp_ff [6];
   logic signed [W2-1:0]   sum_in [6];
   logic signed [W2-1:0]   sum_ff [6];
   logic signed [W3-1:0]   nv_in [2];
   logic signed [W3-1:0]   nv_ff [2];

   assign raw[0]  = in_data.src_p_x;
   assign raw[1]  = in_data.src_p_y;
   assign raw[2]  = in_data.src_q_x;
   assign raw[3]  = in_data.src_q_y;
   assign raw[4]  = in_data.src_r_x;
   assign raw[5]  = in_data.src_r_y;
   assign raw[6]  = in_data.dst_p_x;
   assign raw[7]  = in_data.dst_p_y;
   assign raw[8]  = in_data.dst_q_x;
   assign raw[9]  = in_data.dst_q_y;
   assign raw[10] = in_data.dst_r_x;
   assign raw[11] = in_data.dst_r_y;

   // take the low COORD_BITS of each field as a signed coordinate
   always_comb begin
      for (int i = 0; i < NC; i++) begin
         ext[i] = {{C{1'b0}}, raw[i]};
         crd[i] = ext[i][C-1:0];
      end
   end

   // stage 1: coordinate differences and inner translation products
   always_comb begin
      for (int r = 0; r < 5; r++) begin
         for (int k = 0; k < 3; k++) begin
            dif_in[r][k] = W1'(crd[aff3p_pkg::DIFF_HI[r][k]])
                         - W1'(crd[aff3p_pkg::DIFF_LO[r][k]]);
         end
      end
      for (int t = 0; t < 6; t++) begin
         ti_in[t] = WI'(crd[aff3p_pkg::TI_A[t]] * crd[aff3p_pkg::TI_B[t]])
                  - WI'(crd[aff3p_pkg::TI_C[t]] * crd[aff3p_pkg::TI_D[t]]);
      end
   end

   // stage 2: outer products
   always_comb begin
      for (int s = 0; s < 6; s++) begin
         for (int k = 0; k < 3; k++) begin
            pr_in[s][k] = WI'(dif_ff[aff3p_pkg::SUM_ROW[s]][k])
                        * WI'(c1_ff[aff3p_pkg::SUM_MUL[s][k]]);
         end
      end
      for (int t = 0; t < 6; t++) begin
         tp_in[t] = WT'(ti_ff[t]) * WT'(c1_ff[aff3p_pkg::TI_M[t]]);
      end
   end

   // stage 3: three-term sums
   always_comb begin
      for (int s = 0; s < 6; s++) begin
         sum_in[s] = W2'(pr_ff[s][0]) + W2'(pr_ff[s][1]) + W2'(pr_ff[s][2]);
      end
      nv_in[0] = W3'(tp_ff[0]) + W3'(tp_ff[1]) + W3'(tp_ff[2]);
      nv_in[1] = W3'(tp_ff[3]) + W3'(tp_ff[4]) + W3'(tp_ff[5]);
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (enable) begin
         c1_ff  <= crd;
         dif_ff <= dif_in;
         ti_ff  <= ti_in;
         pr_ff  <= pr_in;
         tp_ff  <= tp_in;
         sum_ff <= sum_in;
         nv_ff  <= nv_in;
      end
   end

   // classification of the finished item
   assign out_valid    = v3_ff;
   assign out_d        = sum_ff[0];
   assign out_src_zero = (sum_ff[0] == '0);
   assign out_dst_zero = (sum_ff[1] == '0);
   assign out_nm[0]    = sum_ff[2];
   assign out_nm[1]    = sum_ff[3];
   assign out_nm[2]    = sum_ff[4];
   assign out_nm[3]    = sum_ff[5];
   assign out_nvx      = nv_ff[0];
   assign out_nvy      = nv_ff[1];

endmodule

`default_nettype wire

### rtl/aff3p_queue.sv
`default_nettype none

module aff3p_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int DEPTH = aff3p_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNTW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = slot_ff[rd_ff];

   // pointer and fill count
   always_comb begin
      wr_in  = push ? wr_ff + PW'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + PW'(1) : rd_ff;
      cnt_in = cnt_ff + CNTW'(push) - CNTW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/aff3p_back.sv
`default_nettype none

module aff3p_back #(
   parameter int COORD_BITS    = aff3p_pkg::COORD_BITS_DEF,
   parameter int OUT_FRAC_BITS = aff3p_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic                            in_src_zero,
   input  logic                            in_dst_zero,
   input  logic signed [2*COORD_BITS+2:0]  in_d,
   input  logic signed [2*COORD_BITS+2:0]  in_nm [4],
   input  logic signed [3*COORD_BITS+2:0]  in_nvx,
   input  logic signed [3*COORD_BITS+2:0]  in_nvy,
   output logic                            in_pop,
   output logic                            out_valid,
   input  logic                            out_stall,
   output aff3p_pkg::rsp_type              out_data
);

   localparam int C   = COORD_BITS;
   localparam int F   = OUT_FRAC_BITS;
   localparam int L   = aff3p_pkg::NUM_LANES;
   localparam int QB  = aff3p_pkg::OUT_W;
   localparam int W2  = 2 * C + 3;
   localparam int W3  = 3 * C + 3;
   localparam int DW  = W2 + 1;
   localparam int NWM = W3 + F + 2;
   localparam int NW  = (NWM > QB + 1) ? NWM : QB + 1;
   localparam int HW  = NW - QB;
   localparam int CW  = (HW > DW) ? HW : DW;
   localparam int SHM = F + 1;
   localparam int SHT = F - aff3p_pkg::COORD_FRAC + 1;

   logic                  en;

   // setup stage signals
   logic                  dneg;
   logic [W2-1:0]         dmag;
   logic [DW-1:0]         den0;
   logic signed [W3-1:0]  num [L];
   logic                  nneg [L];
   logic [W3-1:0]         nmag [L];
   logic [NW-1:0]         np [L];
   logic [HW-1:0]         hi [L];
   logic [DW-1:0]         rem0 [L];
   logic [QB-1:0]         lq0 [L];
   logic                  neg0 [L];
   logic                  ovf0 [L];

   // divider stages: index 0 is the setup register, QB is the last step
   logic                  v_ff    [QB+1];
   logic                  sz_ff   [QB+1];
   logic                  dz_ff   [QB+1];
   logic [DW-1:0]         den_ff  [QB+1];
   logic [DW-1:0]         rem_ff  [QB+1][L];
   logic [DW-1:0]         rem_in  [QB+1][L];
   logic [QB-1:0]         lq_ff   [QB+1][L];
   logic [QB-1:0]         lq_in   [QB+1][L];
   logic                  neg_ff  [QB+1][L];
   logic                  ovf_ff  [QB+1][L];
   logic [DW:0]           trial   [QB+1][L];
   logic                  ge      [QB+1][L];

   // result stage
   logic [QB-1:0]         lim [L];
   logic [QB-1:0]         mag [L];
   logic [QB-1:0]         val [L];
   logic                  sat [L];
   logic                  any_sat;
   logic                  rsp_valid_ff;
   aff3p_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   assign en        = !rsp_valid_ff || !out_stall;
   assign in_pop    = en && in_valid;
   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_data_ff;

   // setup: magnitudes, rounding bias, overflow test on the top quotient bits
   always_comb begin
      dneg = in_d[W2-1];
      dmag = dneg ? W2'(-in_d) : W2'(in_d);
      den0 = {dmag, 1'b0};
      num[0] = W3'(in_nm[0]);
      num[1] = W3'(in_nm[1]);
      num[2] = W3'(in_nm[2]);
      num[3] = W3'(in_nm[3]);
      num[4] = in_nvx;
      num[5] = in_nvy;
      for (int k = 0; k < L; k++) begin
         nneg[k] = num[k][W3-1];
         nmag[k] = nneg[k] ? W3'(-num[k]) : W3'(num[k]);
         if (k < 4) begin
            np[k] = (NW'(nmag[k]) << SHM) + NW'(dmag);
         end else begin
            np[k] = (NW'(nmag[k]) << SHT) + NW'(dmag);
         end
         hi[k]   = np[k][NW-1:QB];
         ovf0[k] = (CW'(hi[k]) >= CW'(den0));
         rem0[k] = DW'(CW'(hi[k]));
         lq0[k]  = np[k][QB-1:0];
         neg0[k] = nneg[k] ^ dneg;
      end
   end

   // one restoring quotient bit per stage; low dividend bits shift out
   // the top of lq while quotient bits shift in at the bottom
   always_comb begin
      for (int s = 0; s <= QB; s++) begin
         for (int k = 0; k < L; k++) begin
            trial[s][k]  = '0;
            ge[s][k]     = 1'b0;
            rem_in[s][k] = rem0[k];
            lq_in[s][k]  = lq0[k];
         end
      end
      for (int s = 1; s <= QB; s++) begin
         for (int k = 0; k < L; k++) begin
            trial[s][k] = {rem_ff[s-1][k], lq_ff[s-1][k][QB-1]};
            ge[s][k]    = (trial[s][k] >= {1'b0, den_ff[s-1]});
            if (ge[s][k]) begin
               rem_in[s][k] = DW'(trial[s][k] - {1'b0, den_ff[s-1]});
            end else begin
               rem_in[s][k] = trial[s][k][DW-1:0];
            end
            lq_in[s][k] = {lq_ff[s-1][k][QB-2:0], ge[s][k]};
         end
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QB; s++) begin
            v_ff[s] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s <= QB; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
         rsp_valid_ff <= v_ff[QB];
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         sz_ff[0]  <= in_src_zero;
         dz_ff[0]  <= in_dst_zero;
         den_ff[0] <= den0;
         for (int k = 0; k < L; k++) begin
            neg_ff[0][k] <= neg0[k];
            ovf_ff[0][k] <= ovf0[k];
         end
         for (int s = 1; s <= QB; s++) begin
            sz_ff[s]  <= sz_ff[s-1];
            dz_ff[s]  <= dz_ff[s-1];
            den_ff[s] <= den_ff[s-1];
            for (int k = 0; k < L; k++) begin
               neg_ff[s][k] <= neg_ff[s-1][k];
               ovf_ff[s][k] <= ovf_ff[s-1][k];
            end
         end
         for (int s = 0; s <= QB; s++) begin
            for (int k = 0; k < L; k++) begin
               rem_ff[s][k] <= rem_in[s][k];
               lq_ff[s][k]  <= lq_in[s][k];
            end
         end
         rsp_data_ff <= rsp_data_in;
      end
   end

   // clamp, apply sign, pick status
   always_comb begin
      any_sat = 1'b0;
      for (int k = 0; k < L; k++) begin
         if (neg_ff[QB][k]) begin
            lim[k] = QB'(1) << (QB - 1);
         end else begin
            lim[k] = (QB'(1) << (QB - 1)) - QB'(1);
         end
         sat[k]  = ovf_ff[QB][k] || (lq_ff[QB][k] > lim[k]);
         mag[k]  = sat[k] ? lim[k] : lq_ff[QB][k];
         val[k]  = neg_ff[QB][k] ? QB'(-mag[k]) : mag[k];
         any_sat = any_sat | sat[k];
      end
      rsp_data_in.m00     = val[0];
      rsp_data_in.m01     = val[1];
      rsp_data_in.m10     = val[2];
      rsp_data_in.m11     = val[3];
      rsp_data_in.shift_x = val[4];
      rsp_data_in.shift_y = val[5];
      rsp_data_in.status  = any_sat ? aff3p_pkg::ST_SAT : aff3p_pkg::ST_OK;
      if (sz_ff[QB] || dz_ff[QB]) begin
         rsp_data_in.m00     = '0;
         rsp_data_in.m01     = '0;
         rsp_data_in.m10     = '0;
         rsp_data_in.m11     = '0;
         rsp_data_in.shift_x = '0;
         rsp_data_in.shift_y = '0;
         rsp_data_in.status  = sz_ff[QB] ? aff3p_pkg::ST_SRC_DEGEN
                                         : aff3p_pkg::ST_DST_DEGEN;
      end
   end

endmodule

`default_nettype wire

### rtl/affine_from_three_points_top.sv
`default_nettype none

// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_data  (aff3p_pkg::req_type)
// rsp      out        rsp_valid/rsp_stall  rsp_data  (aff3p_pkg::rsp_type)
//
// One transfer per cycle in each direction when nothing stalls.
// An item passes three front stages, one queue slot, a setup stage, one
// restoring divider stage per quotient bit (48) and the output register on its
// way from request transfer to result transfer.
// Reset is synchronous and clears all valid and queue state.
// req_stall rises only when the four-entry queue is full; rsp_stall freezes
// the back pipeline while a result is held, and it then drains the queue no further.

module affine_from_three_points_top #(
   parameter int COORD_BITS    = aff3p_pkg::COORD_BITS_DEF,
   parameter int OUT_FRAC_BITS = aff3p_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  aff3p_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output aff3p_pkg::rsp_type rsp_data
);

   localparam int W2 = 2 * COORD_BITS + 3;
   localparam int W3 = 3 * COORD_BITS + 3;
   localparam int EW = 2 + 5 * W2 + 2 * W3;

   logic                 f_valid, f_src_zero, f_dst_zero;
   logic signed [W2-1:0] f_d;
   logic signed [W2-1:0] f_nm [4];
   logic signed [W3-1:0] f_nvx, f_nvy;

   logic                 q_full, q_empty, q_pop;
   logic [EW-1:0]        q_wdata, q_rdata;
   logic                 q_src_zero, q_dst_zero;
   logic signed [W2-1:0] q_d;
   logic signed [W2-1:0] q_nm [4];
   logic signed [W3-1:0] q_nvx, q_nvy;

   assign req_stall = q_full;

   aff3p_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_data      (req_data),
      .enable       (!q_full),
      .out_valid    (f_valid),
      .out_src_zero (f_src_zero),
      .out_dst_zero (f_dst_zero),
      .out_d        (f_d),
      .out_nm       (f_nm),
      .out_nvx      (f_nvx),
      .out_nvy      (f_nvy)
   );

   // pack one classified item into a queue entry
   assign q_wdata = {f_src_zero, f_dst_zero, f_d, f_nm[0], f_nm[1], f_nm[2], f_nm[3],
                     f_nvx, f_nvy};

   aff3p_queue #(
      .WIDTH (EW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid && !q_full),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   assign {q_src_zero, q_dst_zero, q_d, q_nm[0], q_nm[1], q_nm[2], q_nm[3],
           q_nvx, q_nvy} = q_rdata;

   aff3p_back #(
      .COORD_BITS    (COORD_BITS),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (!q_empty),
      .in_src_zero (q_src_zero),
      .in_dst_zero (q_dst_zero),
      .in_d        (q_d),
      .in_nm       (q_nm),
      .in_nvx      (q_nvx),
      .in_nvy      (q_nvy),
      .in_pop      (q_pop),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_data    (rsp_data)
   );

endmodule

`default_nettype wire

### tb/affine_from_three_points_top_tb.sv
`timescale 1ns / 100ps

module affine_from_three_points_top_tb;

   localparam int WATCHDOG_LIMIT = 5000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   aff3p_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   aff3p_pkg::rsp_type rsp_data;

   aff3p_pkg::rsp_type expected_transforms[$];
   int      error_count;
   int      items_sent;
   int      transforms_checked;
   int      src_degen_seen;
   int      dst_degen_seen;
   int      sat_seen;
   int      stall_free_cycles;
   bit      sender_idle_en;
   bit      receiver_idle_en;
   bit      hold_rsp;

   affine_from_three_points_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // round(num * 2^sh / den), ties away from zero, clamped to 48 bits
   function automatic logic [aff3p_pkg::OUT_W-1:0] round_div(
         input logic signed [127:0] num, input logic signed [63:0] den,
         input int sh, inout bit sat);
      logic [127:0] mag_num;
      logic [127:0] mag_den;
      logic [127:0] quo;
      logic [127:0] lim;
      logic [63:0]  den_abs;
      bit           neg;
      neg     = num[127] ^ den[63];
      mag_num = num[127] ? -num : num;
      den_abs = den[63] ? -den : den;
      mag_den = {64'd0, den_abs};
      quo     = ((mag_num << (sh + 1)) + mag_den) / (mag_den << 1);
      if (quo == 0) return '0;
      lim = ((128'd1 << (aff3p_pkg::OUT_W - 1)) - 1) + (neg ? 1 : 0);
      if (quo > lim) begin
         sat = 1'b1;
         quo = lim;
      end
      return neg ? -quo[aff3p_pkg::OUT_W-1:0] : quo[aff3p_pkg::OUT_W-1:0];
   endfunction

   function automatic logic signed [63:0] doubled_area(input logic signed [63:0] ax, ay,
                                                       bx, by, cx, cy);
      return (cy - ay) * bx + (ay - by) * cx + (by - cy) * ax;
   endfunction

   // expected transform for one triangle pair
   function automatic aff3p_pkg::rsp_type solve_affine(input aff3p_pkg::req_type r);
      logic signed [63:0]  px, py, qx, qy, rx, ry, sx0, sy0, sx1, sy1, sx2, sy2;
      logic signed [63:0]  d_src, d_dst;
      logic signed [127:0] num_x, num_y;
      aff3p_pkg::rsp_type  t;
      bit                  sat;
      px  = r.src_p_x; py  = r.src_p_y; qx  = r.src_q_x;
      qy  = r.src_q_y; rx  = r.src_r_x; ry  = r.src_r_y;
      sx0 = r.dst_p_x; sy0 = r.dst_p_y; sx1 = r.dst_q_x;
      sy1 = r.dst_q_y; sx2 = r.dst_r_x; sy2 = r.dst_r_y;
      t     = '0;
      sat   = 1'b0;
      d_src = doubled_area(px, py, qx, qy, rx, ry);
      d_dst = doubled_area(sx0, sy0, sx1, sy1, sx2, sy2);
      if (d_src == 0) begin
         t.status = aff3p_pkg::ST_SRC_DEGEN;
         return t;
      end
      if (d_dst == 0) begin
         t.status = aff3p_pkg::ST_DST_DEGEN;
         return t;
      end
      t.m00 = round_div(128'((sx0 - sx2) * qy + (sx1 - sx0) * ry + (sx2 - sx1) * py),
                        d_src, aff3p_pkg::OUT_FRAC_BITS_DEF, sat);
      t.m01 = round_div(128'((sx2 - sx0) * qx + (sx0 - sx1) * rx + (sx1 - sx2) * px),
                        d_src, aff3p_pkg::OUT_FRAC_BITS_DEF, sat);
      t.m10 = round_div(128'((sy0 - sy2) * qy + (sy1 - sy0) * ry + (sy2 - sy1) * py),
                        d_src, aff3p_pkg::OUT_FRAC_BITS_DEF, sat);
      t.m11 = round_div(128'((sy2 - sy0) * qx + (sy0 - sy1) * rx + (sy1 - sy2) * px),
                        d_src, aff3p_pkg::OUT_FRAC_BITS_DEF, sat);
      num_x = 128'(ry * sx0 - sx2 * py) * 128'(qx) + 128'(sx1 * py - qy * sx0) * 128'(rx)
            + 128'(qy * sx2 - sx1 * ry) * 128'(px);
      num_y = 128'(sy2 * px - rx * sy0) * 128'(qy) + 128'(sy0 * qx - px * sy1) * 128'(ry)
            + 128'(rx * sy1 - sy2 * qx) * 128'(py);
      t.shift_x = round_div(num_x, d_src,
                            aff3p_pkg::OUT_FRAC_BITS_DEF - aff3p_pkg::COORD_FRAC, sat);
      t.shift_y = round_div(num_y, d_src,
                            aff3p_pkg::OUT_FRAC_BITS_DEF - aff3p_pkg::COORD_FRAC, sat);
      t.status  = sat ? aff3p_pkg::ST_SAT : aff3p_pkg::ST_OK;
      return t;
   endfunction

   // one request transfer, with an optional idle burst in front
   task automatic send_pair(input aff3p_pkg::req_type item);
      @(negedge clock);
      if (sender_idle_en && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (req_stall);
      expected_transforms.push_back(solve_affine(item));
      items_sent++;
   endtask

   task automatic send_coords(input logic signed [15:0] a, b, c, d, e, f,
                              g, h, i, j, k, l);
      send_pair('{a, b, c, d, e, f, g, h, i, j, k, l});
   endtask

   // random triangle pair, weighted toward well-formed inputs
   function automatic aff3p_pkg::req_type random_pair();
      aff3p_pkg::req_type r;
      int                 mode;
      logic signed [15:0] bx, by, dx, dy;
      int                 ka, kb;
      mode = $urandom_range(0, 99);
      r    = aff3p_pkg::req_type'({$urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom});
      if (mode < 30) begin
         // moderate coordinates, ordinary transforms
         r.src_p_x = $urandom_range(0, 4095) - 2048; r.src_p_y = $urandom_range(0, 4095) - 2048;
         r.src_q_x = $urandom_range(0, 4095) - 2048; r.src_q_y = $urandom_range(0, 4095) - 2048;
         r.src_r_x = $urandom_range(0, 4095) - 2048; r.src_r_y = $urandom_range(0, 4095) - 2048;
      end else if (mode < 40) begin
         // tiny source triangle: large coefficients, likely clamping
         r.src_q_x = r.src_p_x + $urandom_range(0, 4) - 2;
         r.src_q_y = r.src_p_y + $urandom_range(0, 4) - 2;
         r.src_r_x = r.src_p_x + $urandom_range(0, 4) - 2;
         r.src_r_y = r.src_p_y + $urandom_range(0, 4) - 2;
         r.src_p_x = r.src_p_x >>> 1; r.src_q_x = r.src_q_x >>> 1; r.src_r_x = r.src_r_x >>> 1;
      end else if (mode < 50 || (mode >= 50 && mode < 60)) begin
         // collinear points on one side
         bx = $urandom_range(0, 20000) - 10000; by = $urandom_range(0, 20000) - 10000;
         dx = $urandom_range(0, 200) - 100;     dy = $urandom_range(0, 200) - 100;
         ka = $urandom_range(0, 100) - 50;      kb = $urandom_range(0, 100) - 50;
         if (mode < 50) begin
            r.src_p_x = bx; r.src_p_y = by;
            r.src_q_x = bx + ka * dx; r.src_q_y = by + ka * dy;
            r.src_r_x = bx + kb * dx; r.src_r_y = by + kb * dy;
         end else begin
            r.dst_p_x = bx; r.dst_p_y = by;
            r.dst_q_x = bx + ka * dx; r.dst_q_y = by + ka * dy;
            r.dst_r_x = bx + kb * dx; r.dst_r_y = by + kb * dy;
         end
      end
      return r;
   endfunction

   task automatic test_directed();
      // all zero, both degenerate, target only degenerate
      send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_coords(0, 0, 16, 16, 32, 32, 0, 0, 16, 16, 32, 32);
      send_coords(0, 0, 16, 0, 0, 16, 5, 5, 5, 5, 5, 5);
      send_coords(0, 0, 16, 0, 0, 16, 0, 0, 16, 16, 32, 32);
      // identity, scaling, mirror (negative area), translation
      send_coords(0, 0, 16, 0, 0, 16, 0, 0, 16, 0, 0, 16);
      send_coords(0, 0, 16, 0, 0, 16, 0, 0, 32, 0, 0, 48);
      send_coords(0, 0, 0, 16, 16, 0, 100, -50, 100, -34, 116, -50);
      send_coords(10, 20, 26, 20, 10, 36, -90, 77, -74, 77, -90, 93);
      // thirds and rounding ties
      send_coords(0, 0, 3, 0, 0, 3, 0, 0, 1, 0, 0, 2);
      send_coords(0, 0, 3, 0, 0, 1, 1, 1, 2, 3, 5, 7);
      send_coords(0, 0, 2, 0, 0, 2, 1, 0, 0, 1, 1, 1);
      send_coords(1, 1, -2, 3, 7, -5, -3, 2, 4, 9, -1, -7);
      // field extremes and clamping
      send_coords(-32768, -32768, 32767, -32768, -32768, 32767,
                  32767, 32767, -32768, 32767, 32767, -32768);
      send_coords(32767, 32767, -32768, -32768, 32767, -32768,
                  -32768, 32767, 32767, 32767, -32768, -32768);
      send_coords(0, 0, 1, 0, 0, 1, 32767, -32768, -32768, 32767, 32767, 32767);
      send_coords(-32768, 0, -32767, 0, -32768, 1, -32768, -32768, 32767, -32768, 0, 32767);
      send_coords(32767, 32767, 32766, 32767, 32767, 32766, 0, 0, 32767, 0, 0, -32768);
      send_coords(-1, -1, 0, -1, -1, 0, -32768, -32768, 32767, 32767, -32768, 32767);
      send_coords(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h0F0F, 16'hF0F0,
                  16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hF0F0, 16'h0F0F);
      send_coords(0, 0, -1, -1, 1, 1, 3, 4, 5, 6, 7, 9);
   endtask

   task automatic test_random(input int count);
      repeat (count) send_pair(random_pair());
   endtask

   // receiver holds off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         test_random(120);
      join
   endtask

   // result side: stall bursts and stretches without stalls
   initial begin
      rsp_stall = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall = 1'b1;
            @(negedge clock);
         end else if (receiver_idle_en && $urandom_range(0, 2) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 15)) if (!hold_rsp) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
            repeat ($urandom_range(1, 20)) if (!hold_rsp) @(negedge clock);
         end
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      aff3p_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_transforms.size() == 0) begin
            $error("unexpected result transfer: %p", rsp_data);
            error_count++;
         end else begin
            want = expected_transforms.pop_front();
            transforms_checked++;
            if (want.status == aff3p_pkg::ST_SRC_DEGEN) src_degen_seen++;
            if (want.status == aff3p_pkg::ST_DST_DEGEN) dst_degen_seen++;
            if (want.status == aff3p_pkg::ST_SAT) sat_seen++;
            if (rsp_data.m00 !== want.m00) begin
               $error("m00: expected %0d, got %0d", want.m00, rsp_data.m00); error_count++;
            end
            if (rsp_data.m01 !== want.m01) begin
               $error("m01: expected %0d, got %0d", want.m01, rsp_data.m01); error_count++;
            end
            if (rsp_data.m10 !== want.m10) begin
               $error("m10: expected %0d, got %0d", want.m10, rsp_data.m10); error_count++;
            end
            if (rsp_data.m11 !== want.m11) begin
               $error("m11: expected %0d, got %0d", want.m11, rsp_data.m11); error_count++;
            end
            if (rsp_data.shift_x !== want.shift_x) begin
               $error("shift_x: expected %0d, got %0d", want.shift_x, rsp_data.shift_x);
               error_count++;
            end
            if (rsp_data.shift_y !== want.shift_y) begin
               $error("shift_y: expected %0d, got %0d", want.shift_y, rsp_data.shift_y);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stall_free_cycles <= 0;
      else
         stall_free_cycles <= stall_free_cycles + 1;
      if (stall_free_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("affine_from_three_points_top verification failed");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      hold_rsp         = 1'b0;
      sender_idle_en   = 1'b1;
      receiver_idle_en = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(1300);
      test_backpressure();
      sender_idle_en   = 1'b0;
      receiver_idle_en = 1'b0;
      test_random(500);

      @(negedge clock);
      req_valid = 1'b0;
      while (expected_transforms.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("covered %0d triangle pairs: %0d source degenerate, %0d target degenerate,",
               transforms_checked, src_degen_seen, dst_degen_seen);
      $display("%0d clamped, with random stalls on both sides and one long hold-off", sat_seen);
      if (error_count == 0 && expected_transforms.size() == 0)
         $display("affine_from_three_points_top verification clean");
      else
         $display("affine_from_three_points_top verification failed");
      $finish;
   end

endmodule

### filelist.f
rtl/aff3p_pkg.sv
rtl/aff3p_front.sv
rtl/aff3p_queue.sv
rtl/aff3p_back.sv
rtl/affine_from_three_points_top.sv
tb/affine_from_three_points_top_tb.sv
